### hdl/hcbp_pkg.sv
`default_nettype none
package hcbp_pkg;

    localparam int CMD_W       = 2;
    localparam int SYM_W       = 8;
    localparam int CODE_W      = 24;
    localparam int LEN_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int PAD_W       = 3;
    localparam int PEND_W      = BYTE_W - 1;
    localparam int ACC_W       = PEND_W + CODE_W;
    localparam int CNT_W       = $clog2(ACC_W + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int DEF_MAX_CODE_LEN = 24;
    localparam int DEF_NUM_SYMBOLS  = 256;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    // work handed from the front end to the packer
    typedef struct packed {
        logic              flush;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } op_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [PAD_W-1:0]  pad;
        logic              last;
    } res_t;

endpackage
`default_nettype wire

### hdl/hcbp_front.sv
`default_nettype none
module hcbp_front
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
    parameter int NUM_SYMBOLS  = DEF_NUM_SYMBOLS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [CMD_W-1:0]  command,
    input  wire logic [SYM_W-1:0]  symbol,
    input  wire logic [CODE_W-1:0] code_bits,
    input  wire logic [LEN_W-1:0]  code_length,
    input  wire logic [QCNT_W-1:0] q_count,
    output logic                   q_push,
    output op_t                    q_op
);

    localparam int LEN_LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int IDX_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    logic [CODE_W-1:0]      code_mem_reg [NUM_SYMBOLS];
    logic [LEN_W-1:0]       len_mem_reg  [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] vld_reg;

    logic [CODE_W-1:0] rd_code_reg;
    logic [LEN_W-1:0]  rd_len_reg;
    logic              rd_vld_reg;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_flush_reg, s1_flush_next;

    cmd_t              cmd;
    logic              accept;
    logic              in_range;
    logic [IDX_W-1:0]  idx;
    logic              do_load, do_enc, do_flush;
    logic [LEN_W-1:0]  ld_len;
    logic [CODE_W-1:0] ld_code;

    assign cmd      = cmd_t'(command);
    assign accept   = push & ~full;
    assign in_range = {1'b0, symbol} < (SYM_W + 1)'(NUM_SYMBOLS);
    assign idx      = symbol[IDX_W-1:0];

    always_comb
    begin
        do_load  = 1'b0;
        do_enc   = 1'b0;
        do_flush = 1'b0;
        unique case (cmd)
            CMD_LOAD:   do_load  = accept & in_range;
            CMD_ENCODE: do_enc   = accept & in_range;
            CMD_FLUSH:  do_flush = accept;
            default:    ;
        endcase
    end

    assign ld_len = (code_length > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : code_length;

    always_comb
    begin
        for (int i = 0; i < CODE_W; i++)
        begin
            ld_code[i] = code_bits[i] & (LEN_W'(i) < ld_len);
        end
    end

    // table write on load, registered read on encode
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            code_mem_reg[idx] <= ld_code;
            len_mem_reg[idx]  <= ld_len;
        end
        if (do_enc)
        begin
            rd_code_reg <= code_mem_reg[idx];
            rd_len_reg  <= len_mem_reg[idx];
        end
    end

    assign s1_valid_next = do_enc | do_flush;
    assign s1_flush_next = do_flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_flush_reg <= 1'b0;
        end
        else
        begin
            if (do_load)
            begin
                vld_reg[idx] <= 1'b1;
            end
            if (do_enc)
            begin
                rd_vld_reg <= vld_reg[idx];
            end
            s1_valid_reg <= s1_valid_next;
            s1_flush_reg <= s1_flush_next;
        end
    end

    // never-loaded entry counts as zero length, zero code
    assign q_push     = s1_valid_reg;
    assign q_op.flush = s1_flush_reg;
    assign q_op.code  = (s1_flush_reg || !rd_vld_reg) ? '0 : rd_code_reg;
    assign q_op.len   = (s1_flush_reg || !rd_vld_reg) ? '0 : rd_len_reg;

    // leave room for the word still in the lookup stage
    assign full = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid_reg))
                  >= (QCNT_W + 1)'(QUEUE_DEPTH);

endmodule
`default_nettype wire

### hdl/hcbp_queue.sv
`default_nettype none
module hcbp_queue
    import hcbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire op_t         wr_op,
    input  wire logic        rd_en,
    output op_t              rd_op,
    output logic             rd_valid,
    output logic [QCNT_W-1:0] count
);

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

    assign wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign cnt_next    = cnt_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign rd_op    = slot_reg[rd_ptr_reg];
    assign rd_valid = (cnt_reg != '0);
    assign count    = cnt_reg;

endmodule
`default_nettype wire

### hdl/hcbp_back.sv
`default_nettype none
module hcbp_back
    import hcbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire op_t         q_op,
    output logic             q_pop,
    output logic             empty,
    input  wire logic        pop,
    output logic [BYTE_W-1:0] out_byte,
    output logic [PAD_W-1:0]  pad_bits,
    output logic             last
);

    localparam int OUT_DEPTH = 2;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    res_t             ofifo_reg [OUT_DEPTH];
    logic             owr_reg, ord_reg;
    logic [1:0]       ocnt_reg, ocnt_next;

    logic             out_room;
    logic             has_byte, two_bytes;
    logic             emit_enc, emit_flush;
    logic             take_enc, take_flush;
    logic [CNT_W-1:0] cnt_after;
    logic [CNT_W-1:0] sh;
    logic [CNT_W-1:0] pad_full;
    logic [PAD_W-1:0] pad;
    logic [BYTE_W-1:0] enc_byte, flush_byte;
    logic             res_push;
    res_t             res;
    logic             opop;

    assign out_room  = (ocnt_reg != 2'(OUT_DEPTH));
    assign has_byte  = (cnt_reg >= CNT_W'(BYTE_W));
    assign two_bytes = (cnt_reg >= CNT_W'(2 * BYTE_W));

    assign emit_enc  = has_byte & out_room;
    assign cnt_after = emit_enc ? cnt_reg - CNT_W'(BYTE_W) : cnt_reg;

    // a new code may enter in the cycle that sends the last full byte
    assign take_enc   = q_valid & ~q_op.flush & (~has_byte | (~two_bytes & emit_enc));
    assign take_flush = q_valid & q_op.flush & ~has_byte & ((cnt_reg == '0) | out_room);
    assign emit_flush = take_flush & (cnt_reg != '0);
    assign q_pop      = take_enc | take_flush;

    assign sh       = cnt_reg - CNT_W'(BYTE_W);
    assign enc_byte = BYTE_W'(acc_reg >> sh);
    assign pad_full = CNT_W'(BYTE_W) - cnt_reg;
    assign pad      = pad_full[PAD_W-1:0];
    // stale bits above the count fall off the top
    assign flush_byte = acc_reg[BYTE_W-1:0] << pad;

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_after;
        if (take_enc)
        begin
            acc_next = (acc_reg << q_op.len) | ACC_W'(q_op.code);
            cnt_next = cnt_after + CNT_W'(q_op.len);
        end
        else if (take_flush)
        begin
            cnt_next = '0;
        end
    end

    always_comb
    begin
        res.data = enc_byte;
        res.pad  = '0;
        res.last = ~two_bytes;
        if (emit_flush)
        begin
            res.data = flush_byte;
            res.pad  = pad;
            res.last = 1'b1;
        end
    end

    assign res_push  = emit_enc | emit_flush;
    assign opop      = pop & (ocnt_reg != '0);
    assign ocnt_next = ocnt_reg + 2'(res_push) - 2'(opop);

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (res_push)
        begin
            ofifo_reg[owr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            owr_reg  <= 1'b0;
            ord_reg  <= 1'b0;
            ocnt_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            owr_reg  <= owr_reg ^ res_push;
            ord_reg  <= ord_reg ^ opop;
            ocnt_reg <= ocnt_next;
        end
    end

    assign empty    = (ocnt_reg == '0);
    assign out_byte = ofifo_reg[ord_reg].data;
    assign pad_bits = ofifo_reg[ord_reg].pad;
    assign last     = ofifo_reg[ord_reg].last;

endmodule
`default_nettype wire

### hdl/huffman_code_bit_packer.sv
// Path: an encode word passes the lookup registers, the queue, the bit accumulator and
// the output queue before its first byte shows; a flush byte skips the accumulator.
// Throughput: one word a cycle into the front end while full is low; the packer takes
// a new code word when no full byte is pending or in the cycle that sends the last one,
// and a flush once no full byte is pending; one output byte per cycle at most.
// Reset (rst_n, async, active low) clears table valid bits, pending count, queues.
`default_nettype none
module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
    parameter int NUM_SYMBOLS  = DEF_NUM_SYMBOLS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [CMD_W-1:0]  command,
    input  wire logic [SYM_W-1:0]  symbol,
    input  wire logic [CODE_W-1:0] code_bits,
    input  wire logic [LEN_W-1:0]  code_length,
    output logic                   empty,
    input  wire logic              pop,
    output logic [BYTE_W-1:0]      out_byte,
    output logic [PAD_W-1:0]       pad_bits,
    output logic                   last
);

    logic              q_push;
    op_t               q_wr_op;
    logic              q_pop;
    op_t               q_rd_op;
    logic              q_valid;
    logic [QCNT_W-1:0] q_count;

    hcbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NUM_SYMBOLS  (NUM_SYMBOLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .q_count     (q_count),
        .q_push      (q_push),
        .q_op        (q_wr_op)
    );

    hcbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_op    (q_wr_op),
        .rd_en    (q_pop),
        .rd_op    (q_rd_op),
        .rd_valid (q_valid),
        .count    (q_count)
    );

    hcbp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_op     (q_rd_op),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .pad_bits (pad_bits),
        .last     (last)
    );

endmodule
`default_nettype wire

### hdl/hcbp_checker.sv
`default_nettype none
module hcbp_checker
    import hcbp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              full,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic [BYTE_W-1:0] out_byte,
    input wire logic [PAD_W-1:0]  pad_bits,
    input wire logic              last
);

    // a waiting word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(pad_bits) && $stable(last)))
        else $error("result word changed while stalled");

    // padding only comes from a flush, which always closes its word group
    a_pad_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pad_bits != '0) |-> last)
        else $error("padded byte not marked last");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pad_bits != '0) |-> ((out_byte & ~(8'hFF << pad_bits)) == 8'h00))
        else $error("pad bits not zero");

    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && !full))
        else $error("queues not clear after reset");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .pad_bits (pad_bits),
    .last     (last)
);
`default_nettype wire
